/* sv/sfpe_pkg.sv */
// Package: shared types and constants for the sensor frame pulse encoder.
package sfpe_pkg;

    localparam int SYMBOL_COUNT = 50;
    localparam int SYM_CNT_W    = $clog2(SYMBOL_COUNT);
    localparam int FRAME_BITS   = 40;
    localparam int SHIFT_W      = FRAME_BITS + 8;

    localparam logic [7:0] MODEL_BYTE = 8'h45;
    localparam logic [7:0] DIGEST_GEN = 8'h98;
    localparam logic [7:0] DIGEST_KEY = 8'h3e;
    localparam logic [7:0] DIGEST_XOR = 8'h64;

    localparam logic [14:0] TEMP_OFFSET = 15'd3600;
    // ceil(2^16 / 5), exact for dividends below 2^14
    localparam logic [14:0] RECIP5      = 15'd13108;

    localparam logic [12:0] START0_HI = 13'd4868;
    localparam logic [11:0] START0_LO = 12'd2469;
    localparam logic [12:0] START1_HI = 13'd1647;
    localparam logic [11:0] START1_LO = 12'd315;
    localparam logic [12:0] ONE_HI    = 13'd670;
    localparam logic [11:0] ONE_LO    = 12'd320;
    localparam logic [12:0] ZERO_HI   = 13'd348;
    localparam logic [11:0] ZERO_LO   = 12'd642;

    localparam logic [1:0] REG_SENSOR_ID = 2'd0;
    localparam logic [1:0] REG_CHANNEL   = 2'd1;
    localparam logic [1:0] REG_BATTERY   = 2'd2;
    localparam logic [1:0] REG_HUMIDITY  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic [12:0] high_micros;
        logic [11:0] low_micros;
        logic        last_symbol;
    } t_symbol;

endpackage

/* sv/sensor_frame_pulse_encoder.sv */
// Top level: config registers, control sequencer and output word register.
// Throughput: 50 output words per input word, set by the bit-serial frame shifter,
// one per cycle when the output does not stall; a new input word is taken only
// once the last symbol of the frame has gone out.
// Reset: synchronous active-low; config registers return to their defaults.
module sensor_frame_pulse_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_temp_c_tenths,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_high_micros,
    output logic [11:0] o_low_micros,
    output logic        o_last_symbol,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sfpe_pkg::t_state  r_state;
    sfpe_pkg::t_state  n_state;

    logic [7:0]  r_sensor_id;
    logic [2:0]  r_channel_number;
    logic        r_battery_low;
    logic [7:0]  r_humidity_value;

    logic        r_out_valid;
    sfpe_pkg::t_symbol r_out;

    logic        w_accept;
    logic        w_temp_done;
    logic [11:0] w_field;
    logic [39:0] w_frame;
    logic        w_active;
    logic        w_advance;
    logic        w_wr;
    sfpe_pkg::t_symbol w_sym;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_id      <= 8'd1;
            r_channel_number <= 3'd1;
            r_battery_low    <= 1'b0;
            r_humidity_value <= 8'd50;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                sfpe_pkg::REG_SENSOR_ID: r_sensor_id      <= pwdata[7:0];
                sfpe_pkg::REG_CHANNEL:   r_channel_number <= pwdata[2:0];
                sfpe_pkg::REG_BATTERY:   r_battery_low    <= pwdata[0];
                sfpe_pkg::REG_HUMIDITY:  r_humidity_value <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sfpe_pkg::REG_SENSOR_ID: prdata = {24'd0, r_sensor_id};
            sfpe_pkg::REG_CHANNEL:   prdata = {29'd0, r_channel_number};
            sfpe_pkg::REG_BATTERY:   prdata = {31'd0, r_battery_low};
            sfpe_pkg::REG_HUMIDITY:  prdata = {24'd0, r_humidity_value};
        endcase
    end

    sfpe_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_temp  (i_temp_c_tenths),
        .o_done  (w_temp_done),
        .o_field (w_field)
    );

    assign w_frame = {sfpe_pkg::MODEL_BYTE, r_sensor_id,
                      r_battery_low, r_channel_number, w_field[11:8],
                      w_field[7:0], r_humidity_value};

    assign w_advance = w_active && (!r_out_valid || !i_out_stall);

    sfpe_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_temp_done),
        .i_frame   (w_frame),
        .i_advance (w_advance),
        .o_active  (w_active),
        .o_sym     (w_sym)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfpe_pkg::ST_IDLE: if (i_in_valid)  n_state = sfpe_pkg::ST_CONV;
            sfpe_pkg::ST_CONV: if (w_temp_done) n_state = sfpe_pkg::ST_SEND;
            sfpe_pkg::ST_SEND: begin
                if (w_advance && w_sym.last_symbol) n_state = sfpe_pkg::ST_IDLE;
            end
            default: n_state = sfpe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            sfpe_pkg::ST_IDLE: o_in_stall = 1'b0;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfpe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_sym;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_high_micros = r_out.high_micros;
    assign o_low_micros  = r_out.low_micros;
    assign o_last_symbol = r_out.last_symbol;

endmodule

/* sv/sfpe_temp.sv */
// Temperature conversion: tenths of C to the 12-bit frame field; the scaled magnitude is registered, then the quotient.
module sfpe_temp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [10:0] i_temp,
    output logic        o_done,
    output logic [11:0] o_field
);

    logic [14:0] w_ext;
    logic [14:0] w_n;
    logic [14:0] w_abs;
    logic [28:0] w_prod;

    logic        r_v1;
    logic        r_v2;
    logic        r_neg1;
    logic        r_neg2;
    logic [13:0] r_mag;
    logic [11:0] r_q;

    always_comb begin
        w_ext  = {{4{i_temp[10]}}, i_temp};
        w_n    = (w_ext << 3) + w_ext + sfpe_pkg::TEMP_OFFSET;
        w_abs  = w_n[14] ? (~w_n + 15'd1) : w_n;
        w_prod = 29'(r_mag) * 29'(sfpe_pkg::RECIP5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_neg1 <= w_n[14];
        r_mag  <= w_abs[13:0];
        r_neg2 <= r_neg1;
        r_q    <= w_prod[27:16];
    end

    assign o_done  = r_v2;
    assign o_field = r_neg2 ? (~r_q + 12'd1) : r_q;

endmodule

/* sv/sfpe_serializer.sv */
// Frame serializer: shifts frame bits out one per symbol, digest built on the fly.
module sfpe_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [39:0]          i_frame,
    input  logic                 i_advance,
    output logic                 o_active,
    output sfpe_pkg::t_symbol    o_sym
);

    logic                              r_active;
    logic [sfpe_pkg::SYM_CNT_W-1:0]    r_cnt;
    logic [sfpe_pkg::SHIFT_W-1:0]      r_shift;
    logic [7:0]                        r_key;
    logic [7:0]                        r_sum;

    logic [sfpe_pkg::SHIFT_W-1:0]      n_shift;
    logic [7:0]                        n_key;
    logic [7:0]                        n_sum;
    logic                              w_bit;

    assign w_bit = r_shift[sfpe_pkg::SHIFT_W-1];

    always_comb begin
        n_key   = r_key;
        n_sum   = r_sum;
        n_shift = r_shift;
        if (r_cnt >= sfpe_pkg::SYM_CNT_W'(2)) begin
            n_shift = {r_shift[sfpe_pkg::SHIFT_W-2:0], 1'b0};
            if (r_cnt < sfpe_pkg::SYM_CNT_W'(sfpe_pkg::FRAME_BITS + 2)) begin
                n_sum = w_bit ? (r_sum ^ r_key) : r_sum;
                n_key = r_key[0] ? ((r_key >> 1) ^ sfpe_pkg::DIGEST_GEN) : (r_key >> 1);
            end
            // last frame bit consumed: digest byte fills the top of the shifter
            if (r_cnt == sfpe_pkg::SYM_CNT_W'(sfpe_pkg::FRAME_BITS + 1)) begin
                n_shift[sfpe_pkg::SHIFT_W-1 -: 8] = n_sum ^ sfpe_pkg::DIGEST_XOR;
            end
        end
    end

    always_comb begin
        if (r_cnt == sfpe_pkg::SYM_CNT_W'(0)) begin
            o_sym.high_micros = sfpe_pkg::START0_HI;
            o_sym.low_micros  = sfpe_pkg::START0_LO;
        end else if (r_cnt == sfpe_pkg::SYM_CNT_W'(1)) begin
            o_sym.high_micros = sfpe_pkg::START1_HI;
            o_sym.low_micros  = sfpe_pkg::START1_LO;
        end else if (w_bit) begin
            o_sym.high_micros = sfpe_pkg::ONE_HI;
            o_sym.low_micros  = sfpe_pkg::ONE_LO;
        end else begin
            o_sym.high_micros = sfpe_pkg::ZERO_HI;
            o_sym.low_micros  = sfpe_pkg::ZERO_LO;
        end
        o_sym.last_symbol = (r_cnt == sfpe_pkg::SYM_CNT_W'(sfpe_pkg::SYMBOL_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (i_advance && r_active) begin
            r_cnt <= r_cnt + sfpe_pkg::SYM_CNT_W'(1);
            if (o_sym.last_symbol) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= {i_frame, 8'h00};
            r_key   <= sfpe_pkg::DIGEST_KEY;
            r_sum   <= 8'h00;
        end else if (i_advance && r_active) begin
            r_shift <= n_shift;
            r_key   <= n_key;
            r_sum   <= n_sum;
        end
    end

    assign o_active = r_active;

endmodule
